// ===== sv/spaq_pkg.sv =====
// ----------------------------------------------------------------------------
// spaq_pkg
// Shared types and constants of the sorted array priority queue: queue
// depth, field widths, operation and status codes, cell entry and control.
// ----------------------------------------------------------------------------
`default_nettype none

package spaq_pkg;

  // queue geometry
  localparam int unsigned Depth  = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;

  // requested operation
  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_POP = 1'b1
  } kind_e;

  // result status
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // action broadcast to every cell in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  // one stored entry
  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] prio;
  } entry_t;

  // control bundle from the top level to the cell row
  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] new_value;
    logic [DataW-1:0] new_prio;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/spaq_cell.sv =====
// ----------------------------------------------------------------------------
// spaq_cell
// One slot of the sorted row. Compares the incoming priority with its own,
// and on an insert keeps, takes the new entry or takes its left neighbor;
// on a pop takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spaq_cell (
  input  wire                 clk_i,
  input  spaq_pkg::cell_ctrl_t ctrl_i,
  input  wire                 occupied_i,
  input  spaq_pkg::entry_t    left_i,
  input  wire                 left_greater_i,
  input  spaq_pkg::entry_t    right_i,
  output spaq_pkg::entry_t    entry_o,
  output logic                greater_o
);

  spaq_pkg::entry_t entry_q;
  spaq_pkg::entry_t entry_d;

  // new entry goes behind this slot when its priority is strictly greater
  assign greater_o = occupied_i && ($signed(ctrl_i.new_prio) > $signed(entry_q.prio));

  // next slot content
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      spaq_pkg::OP_INSERT: begin
        if (greater_o) begin
          entry_d = entry_q;
        end else if (left_greater_i) begin
          entry_d.value = ctrl_i.new_value;
          entry_d.prio  = ctrl_i.new_prio;
        end else begin
          entry_d = left_i;
        end
      end
      spaq_pkg::OP_POP: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // slot storage, no reset: occupancy comes from the fill count
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== sv/sorted_array_priority_queue.sv =====
// A result is in the output register from the cycle after its transaction is accepted.
// Throughput: one add or pop per cycle while the result side does not stall;
// the whole cell row shifts or inserts in the same cycle.
// Input stalls only while a held result is itself stalled.
// Reset clears the fill count and the output valid; slot contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Priority queue built as a row of cells kept sorted by ascending signed
// priority; adds insert in place, pops take slot 0 and shift the row down.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_priority_queue (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                kind_i,
  input  wire signed [spaq_pkg::DataW-1:0]   value_i,
  input  wire signed [spaq_pkg::DataW-1:0]   priority_req_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [spaq_pkg::DataW-1:0]  popped_value_o,
  output logic [1:0]                         status_o,
  output logic [spaq_pkg::CountW-1:0]        fill_count_o
);

  spaq_pkg::cell_ctrl_t            ctrl;
  spaq_pkg::entry_t                entry_s   [spaq_pkg::Depth];
  logic [spaq_pkg::Depth-1:0]      greater_s;
  logic [spaq_pkg::Depth-1:0]      occupied_s;

  logic [spaq_pkg::CountW-1:0]     count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic [spaq_pkg::DataW-1:0]      popped_q, popped_d;
  spaq_pkg::status_e               status_q, status_d;
  logic [spaq_pkg::CountW-1:0]     fill_q;

  logic accept;
  logic is_add;
  logic full;
  logic empty;
  logic do_insert;
  logic do_pop;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_add     = (spaq_pkg::kind_e'(kind_i) == spaq_pkg::KIND_ADD);
  assign full       = (count_q == spaq_pkg::CountW'(spaq_pkg::Depth));
  assign empty      = (count_q == '0);
  assign do_insert  = accept && is_add && !full;
  assign do_pop     = accept && !is_add && !empty;

  // broadcast control to the cell row
  always_comb begin
    ctrl.new_value = value_i;
    ctrl.new_prio  = priority_req_i;
    if (do_insert) begin
      ctrl.op = spaq_pkg::OP_INSERT;
    end else if (do_pop) begin
      ctrl.op = spaq_pkg::OP_POP;
    end else begin
      ctrl.op = spaq_pkg::OP_HOLD;
    end
  end

  // row of cells
  for (genvar i = 0; i < spaq_pkg::Depth; i++) begin : g_cell
    spaq_pkg::entry_t left_e;
    spaq_pkg::entry_t right_e;
    logic             left_gt;

    assign occupied_s[i] = (count_q > spaq_pkg::CountW'(i));

    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b1;
    end else begin : g_mid
      assign left_e  = entry_s[i-1];
      assign left_gt = greater_s[i-1];
    end

    if (i == spaq_pkg::Depth - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_s[i+1];
    end

    spaq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (occupied_s[i]),
      .left_i         (left_e),
      .left_greater_i (left_gt),
      .right_i        (right_e),
      .entry_o        (entry_s[i]),
      .greater_o      (greater_s[i])
    );
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + spaq_pkg::CountW'(1);
    end else if (do_pop) begin
      count_d = count_q - spaq_pkg::CountW'(1);
    end
  end

  // result of the current transaction
  always_comb begin
    popped_d = '0;
    status_d = spaq_pkg::ST_DONE;
    if (is_add && full) begin
      status_d = spaq_pkg::ST_FULL;
    end else if (!is_add && empty) begin
      status_d = spaq_pkg::ST_EMPTY;
    end else if (!is_add) begin
      popped_d = entry_s[0].value;
    end
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      fill_q   <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign fill_count_o   = fill_q;

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spaq_pkg::CountW'(spaq_pkg::Depth))
    else $error("fill count above depth");

  // add to a full queue leaves the count and flags full
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_add && full) |=> (count_q == $past(count_q)) &&
      (status_o == spaq_pkg::ST_FULL) && out_valid_o)
    else $error("add on full queue not dropped");

  // pop on empty queue reports empty with value zero
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_add && empty) |=> (status_o == spaq_pkg::ST_EMPTY) &&
      (popped_value_o == '0) && (count_q == '0))
    else $error("pop on empty queue misreported");

  // successful insert grows the count by one and reports it
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + spaq_pkg::CountW'(1)) &&
      (fill_count_o == count_q))
    else $error("insert count mismatch");

  // the two head slots stay in ascending priority order when both are occupied
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > spaq_pkg::CountW'(1)) |->
      ($signed(entry_s[0].prio) <= $signed(entry_s[1].prio)))
    else $error("head entries out of order");

endmodule

`default_nettype wire

// ===== sim/tb_sorted_array_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the sorted array priority queue. A short table of
// adds and pops covers the empty and full cases, the extreme priorities and
// the ordering of ties. Random add and pop traffic follows, mixed so that the
// queue fills and drains, with random gaps and stalls on both channels. Each
// result is checked against a written table result or a behavioral queue.
// ----------------------------------------------------------------------------

module tb_sorted_array_priority_queue;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomOps = 800;
  localparam int unsigned LongHold  = 60;

  // one queue operation, with an optional hand-written result
  typedef struct {
    spaq_pkg::kind_e                 kind;
    logic [spaq_pkg::DataW-1:0]      value;
    logic [spaq_pkg::DataW-1:0]      prio;
    bit                              typed;
    logic [spaq_pkg::DataW-1:0]      t_popped;
    spaq_pkg::status_e               t_status;
    logic [spaq_pkg::CountW-1:0]     t_fill;
  } op_row_t;

  // one result of the queue
  typedef struct {
    logic [spaq_pkg::DataW-1:0]  popped;
    spaq_pkg::status_e           status;
    logic [spaq_pkg::CountW-1:0] fill;
  } result_t;

  // block ports
  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                kind_i         = 1'b0;
  logic signed [spaq_pkg::DataW-1:0]   value_i        = '0;
  logic signed [spaq_pkg::DataW-1:0]   priority_req_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic signed [spaq_pkg::DataW-1:0]   popped_value_o;
  logic [1:0]                          status_o;
  logic [spaq_pkg::CountW-1:0]         fill_count_o;

  // bench queue contents, sorted by ascending priority
  logic [spaq_pkg::DataW-1:0]          held_value [spaq_pkg::Depth];
  logic signed [spaq_pkg::DataW-1:0]   held_prio  [spaq_pkg::Depth];
  int                                  held_count = 0;

  // results still to come from the block, oldest first
  result_t                   awaited[$];
  op_row_t                   script[$];

  int                        mismatches = 0;
  int                        idle_cycles = 0;
  int                        stall_left = 0;
  int                        hold_left = 0;
  bit                        hold_req = 1'b0;
  bit                        idle_on = 1'b1;

  sorted_array_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // apply one operation to the bench queue and return its result
  function automatic result_t sorted_queue_apply(spaq_pkg::kind_e op,
                                                 logic signed [spaq_pkg::DataW-1:0] v,
                                                 logic signed [spaq_pkg::DataW-1:0] p);
    result_t r;
    int slot;
    int i;
    r.popped = '0;
    r.status = spaq_pkg::ST_DONE;
    if (op == spaq_pkg::KIND_ADD) begin
      if (held_count >= spaq_pkg::Depth) begin
        r.status = spaq_pkg::ST_FULL;
      end else begin
        // new entry goes ahead of the first one with equal or higher priority
        slot = 0;
        while (slot < held_count && p > held_prio[slot]) slot++;
        for (i = held_count; i > slot; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[slot] = v;
        held_prio[slot]  = p;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = spaq_pkg::ST_EMPTY;
    end else begin
      // take the head and shift the rest down
      r.popped = held_value[0];
      for (i = 0; i < held_count - 1; i++) begin
        held_value[i] = held_value[i+1];
        held_prio[i]  = held_prio[i+1];
      end
      held_count--;
    end
    r.fill = spaq_pkg::CountW'(held_count);
    return r;
  endfunction

  function automatic op_row_t make_row(spaq_pkg::kind_e k, logic [spaq_pkg::DataW-1:0] v,
                                       logic [spaq_pkg::DataW-1:0] p, bit typed,
                                       logic [spaq_pkg::DataW-1:0] pop,
                                       spaq_pkg::status_e st,
                                       logic [spaq_pkg::CountW-1:0] fill);
    op_row_t row;
    row.kind     = k;
    row.value    = v;
    row.prio     = p;
    row.typed    = typed;
    row.t_popped = pop;
    row.t_status = st;
    row.t_fill   = fill;
    return row;
  endfunction

  task automatic report_mismatch(string field, logic [spaq_pkg::DataW-1:0] got,
                                 logic [spaq_pkg::DataW-1:0] want);
    $display("mismatch at %0t: %s got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // drive one transaction at the falling edge, wait for it to be taken
  task automatic send_op(input op_row_t row);
    int gap;
    result_t res;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= row.kind;
    value_i        <= row.value;
    priority_req_i <= row.prio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = sorted_queue_apply(row.kind, row.value, row.prio);
    if (row.typed) begin
      res.popped = row.t_popped;
      res.status = row.t_status;
      res.fill   = row.t_fill;
    end
    awaited.push_back(res);
    @(negedge clk_i);
  endtask

  // result side stalls: long hold first, then per-result wait
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected transaction", popped_value_o, '0);
        end else begin
          want = awaited.pop_front();
          if (popped_value_o !== want.popped)
            report_mismatch("popped_value", popped_value_o, want.popped);
          if (status_o !== want.status)
            report_mismatch("status", spaq_pkg::DataW'(status_o),
                            spaq_pkg::DataW'(want.status));
          if (fill_count_o !== want.fill)
            report_mismatch("fill_count", spaq_pkg::DataW'(fill_count_o),
                            spaq_pkg::DataW'(want.fill));
        end
        stall_left = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    op_row_t row;
    int n;
    int mix;
    int add_pct;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty pop, extreme priorities, ties
    script.push_back(make_row(spaq_pkg::KIND_POP, 32'h1234_5678, 32'h0, 1, '0,
                              spaq_pkg::ST_EMPTY, 5'd0));
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '0,
                              spaq_pkg::ST_DONE, 5'd1));
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'h8000_0000, 32'h8000_0000, 1, '0,
                              spaq_pkg::ST_DONE, 5'd2));
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'd5, 32'd0, 1, '0,
                              spaq_pkg::ST_DONE, 5'd3));
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'd6, 32'd0, 1, '0,
                              spaq_pkg::ST_DONE, 5'd4));
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '0,
                              spaq_pkg::ST_DONE, 5'd5));
    script.push_back(make_row(spaq_pkg::KIND_POP, 32'h0, 32'h0, 1, 32'h8000_0000,
                              spaq_pkg::ST_DONE, 5'd4));
    script.push_back(make_row(spaq_pkg::KIND_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                              32'hFFFF_FFFF, spaq_pkg::ST_DONE, 5'd3));
    // fill up with positive priorities
    for (n = 0; n < 13; n++) begin
      script.push_back(make_row(spaq_pkg::KIND_ADD, $urandom(), $urandom_range(1, 1000), 0,
                                '0, spaq_pkg::ST_DONE, '0));
    end
    // add when full, then ties come out newest first
    script.push_back(make_row(spaq_pkg::KIND_ADD, 32'hDEAD_BEEF, 32'h8000_0000, 1, '0,
                              spaq_pkg::ST_FULL, 5'd16));
    script.push_back(make_row(spaq_pkg::KIND_POP, 32'h0, 32'h0, 1, 32'd6,
                              spaq_pkg::ST_DONE, 5'd15));
    script.push_back(make_row(spaq_pkg::KIND_POP, 32'h0, 32'h0, 1, 32'd5,
                              spaq_pkg::ST_DONE, 5'd14));

    foreach (script[i]) send_op(script[i]);

    // random traffic in segments that fill, drain or mix
    for (n = 0; n < RandomOps; n++) begin
      if (n % 40 == 0) begin
        mix     = $urandom_range(0, 2);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      // receiver holds off while items keep coming
      if (n == 300) begin
        idle_on  = 1'b1;
        hold_req = 1'b1;
      end
      // sender waits until the block has drained its results
      if (n == 550) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (awaited.size() != 0);
      end
      case (mix)
        0:       add_pct = 85;
        1:       add_pct = 15;
        default: add_pct = 50;
      endcase
      row.kind  = ($urandom_range(1, 100) <= add_pct) ? spaq_pkg::KIND_ADD
                                                       : spaq_pkg::KIND_POP;
      row.value = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: row.prio = $urandom_range(0, 8) - 4;
        4: begin
          case ($urandom_range(0, 3))
            0:       row.prio = 32'h8000_0000;
            1:       row.prio = 32'h7FFF_FFFF;
            2:       row.prio = 32'h0;
            default: row.prio = 32'hFFFF_FFFF;
          endcase
        end
        default: row.prio = $urandom();
      endcase
      row.typed = 1'b0;
      send_op(row);
    end

    // drain, then let the block run idle to catch any late misbehavior
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited.size() != 0);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spaq_pkg.sv
sv/spaq_cell.sv
sv/sorted_array_priority_queue.sv
sim/tb_sorted_array_priority_queue.sv
